// ===== hw/rtl/refcounted_slot_allocator_top_assert.svh =====
// Assertion macros used by the slot allocator core
`ifndef REFCOUNTED_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define REFCOUNTED_SLOT_ALLOCATOR_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define RCSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rcsa assertion failed");

// next-cycle implication
`define RCSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rcsa assertion failed");

`endif

// ===== hw/rtl/rcsa_pkg.sv =====
// Package: sizes, types, codes and width helpers for the slot allocator
package rcsa_pkg;

    localparam int SLOTS      = 256;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_IN_W  = 8;
    localparam int COUNT_OUT_W = 16;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W   = 3;
    localparam int OPCODE_W   = 2;

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DEPTH_W = $clog2(SLOTS + 1);

    localparam int SLOT_EXT_W  = (SLOT_W > SLOT_IN_W) ? SLOT_W : SLOT_IN_W;
    localparam int CMP_W       = (DEPTH_W > SLOT_IN_W) ? DEPTH_W : SLOT_IN_W;
    localparam int COUNT_EXT_W = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
    localparam int VALUE_EXT_W = (VALUE_BITS > VALUE_IN_W) ? VALUE_BITS : VALUE_IN_W;

    typedef logic [SLOT_W-1:0]     slot_t;
    typedef logic [DEPTH_W-1:0]    depth_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [VALUE_BITS-1:0] value_t;

    localparam count_t COUNT_MAX = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT  = 2'd0,
        OP_RETAIN  = 2'd1,
        OP_RELEASE = 2'd2,
        OP_PEEK    = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_FULL      = 3'd1,
        ST_NOT_ALLOC = 3'd2,
        ST_REL_ZERO  = 3'd3,
        ST_SATURATED = 3'd4
    } status_t;

    // memory requests from the core to the count and free-stack RAMs
    typedef struct packed {
        logic   rd_en;
        slot_t  cnt_raddr;
        slot_t  stk_raddr;
        logic   cnt_we;
        slot_t  cnt_waddr;
        count_t cnt_wdata;
        logic   stk_we;
        slot_t  stk_waddr;
        slot_t  stk_wdata;
    } mem_req_t;

    function automatic slot_t slot_idx(input logic [SLOT_IN_W-1:0] s);
        logic [SLOT_EXT_W-1:0] t;
        t = SLOT_EXT_W'(s);
        return t[SLOT_W-1:0];
    endfunction

    function automatic logic [SLOT_IN_W-1:0] slot_port(input slot_t s);
        logic [SLOT_EXT_W-1:0] t;
        t = SLOT_EXT_W'(s);
        return t[SLOT_IN_W-1:0];
    endfunction

    function automatic logic [COUNT_OUT_W-1:0] count_port(input count_t c);
        logic [COUNT_EXT_W-1:0] t;
        t = COUNT_EXT_W'(c);
        return t[COUNT_OUT_W-1:0];
    endfunction

    function automatic value_t value_fit(input logic [VALUE_IN_W-1:0] v);
        logic [VALUE_EXT_W-1:0] t;
        t = VALUE_EXT_W'(v);
        return t[VALUE_BITS-1:0];
    endfunction

endpackage

// ===== hw/rtl/refcounted_slot_allocator_top.sv =====
// Top level: reference-counted slot allocator with LIFO free stack
//
// Input channel (in_valid/in_ready) carries one request per transaction:
// opcode (insert, retain, release, peek), slot and value. Output channel
// (out_valid/out_ready) returns exactly one result per request:
// granted_slot, new_count and status.
// A request is taken when the block is idle; the count and free-stack
// RAMs are read at that edge and the read-modify-write completes in the
// update state, loading the result register once it is free. The block
// takes no new request until that update is done, as the registered
// RAM read must come ahead of the update.
// A stalled receiver holds the result register; a request already taken
// waits in its update cycle until the register frees, and in_ready stays
// low meanwhile. A new request may be accepted while a result still waits.
// Reset empties the free stack and the high-water mark; counts at or
// above the high-water mark read as zero, so the RAMs need no clearing pass.
module refcounted_slot_allocator_top
    import rcsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [SLOT_IN_W-1:0]   slot,
    input  logic [VALUE_IN_W-1:0]  value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SLOT_IN_W-1:0]   granted_slot,
    output logic [COUNT_OUT_W-1:0] new_count,
    output logic [STATUS_W-1:0]    status
);

    mem_req_t mem_req;
    count_t   cnt_rdata;
    slot_t    stk_rdata;

    rcsa_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_slot (granted_slot),
        .new_count    (new_count),
        .status       (status),
        .mem_req      (mem_req),
        .cnt_rdata    (cnt_rdata),
        .stk_rdata    (stk_rdata)
    );

    rcsa_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (SLOTS)
    ) u_count_ram (
        .clk   (clk),
        .we    (mem_req.cnt_we),
        .waddr (mem_req.cnt_waddr),
        .wdata (mem_req.cnt_wdata),
        .re    (mem_req.rd_en),
        .raddr (mem_req.cnt_raddr),
        .rdata (cnt_rdata)
    );

    rcsa_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (mem_req.stk_we),
        .waddr (mem_req.stk_waddr),
        .wdata (mem_req.stk_wdata),
        .re    (mem_req.rd_en),
        .raddr (mem_req.stk_raddr),
        .rdata (stk_rdata)
    );

endmodule

// ===== hw/rtl/rcsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data
module rcsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/rcsa_core.sv =====
// Core: request sequencer, read-modify-write of counts and free stack, result register
`include "refcounted_slot_allocator_top_assert.svh"

module rcsa_core
    import rcsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [SLOT_IN_W-1:0]   slot,
    input  logic [VALUE_IN_W-1:0]  value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [SLOT_IN_W-1:0]   granted_slot,
    output logic [COUNT_OUT_W-1:0] new_count,
    output logic [STATUS_W-1:0]    status,
    output mem_req_t               mem_req,
    input  count_t                 cnt_rdata,
    input  slot_t                  stk_rdata
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t                   state_reg, state_next;
    depth_t                   free_depth_reg, free_depth_next;
    depth_t                   high_water_reg, high_water_next;
    logic                     out_valid_reg, out_valid_next;
    logic [SLOT_IN_W-1:0]     granted_slot_reg, granted_slot_next;
    logic [COUNT_OUT_W-1:0]   new_count_reg, new_count_next;
    status_t                  status_reg, status_next;

    opcode_t                  op_reg;
    logic [SLOT_IN_W-1:0]     slot_reg;
    value_t                   value_reg;

    // value store: written on insert, never read back inside the block
    value_t                   value_mem [SLOTS];
    logic                     val_we;
    slot_t                    val_waddr;

    logic                     accept;
    logic                     exec_fire;
    logic                     slot_ok;
    count_t                   cur_cnt;
    count_t                   cnt_inc;
    count_t                   cnt_dec;
    slot_t                    slot_i;
    depth_t                   depth_m1;
    slot_t                    ins_slot;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign exec_fire = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    assign slot_i   = slot_idx(slot_reg);
    assign slot_ok  = CMP_W'(slot_reg) < CMP_W'(high_water_reg);
    // entries at or above the high-water mark were never written and are read as zero
    assign cur_cnt  = slot_ok ? cnt_rdata : '0;
    assign cnt_inc  = cur_cnt + count_t'(1);
    assign cnt_dec  = cur_cnt - count_t'(1);
    assign depth_m1 = free_depth_reg - depth_t'(1);

    always_comb
    begin
        state_next        = state_reg;
        free_depth_next   = free_depth_reg;
        high_water_next   = high_water_reg;
        granted_slot_next = granted_slot_reg;
        new_count_next    = new_count_reg;
        status_next       = status_reg;
        out_valid_next    = out_ready ? 1'b0 : out_valid_reg;
        ins_slot          = '0;
        val_we            = 1'b0;
        val_waddr         = '0;

        mem_req           = '0;
        mem_req.rd_en     = accept;
        mem_req.cnt_raddr = slot_idx(slot);
        mem_req.stk_raddr = depth_m1[SLOT_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next        = S_IDLE;
                    out_valid_next    = 1'b1;
                    granted_slot_next = slot_reg;
                    new_count_next    = '0;
                    status_next       = ST_OK;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if ((free_depth_reg != '0) || (high_water_reg != depth_t'(SLOTS)))
                            begin
                                if (free_depth_reg != '0)
                                begin
                                    ins_slot        = stk_rdata;
                                    free_depth_next = depth_m1;
                                end
                                else
                                begin
                                    ins_slot        = high_water_reg[SLOT_W-1:0];
                                    high_water_next = high_water_reg + depth_t'(1);
                                end
                                val_we            = 1'b1;
                                val_waddr         = ins_slot;
                                mem_req.cnt_we    = 1'b1;
                                mem_req.cnt_waddr = ins_slot;
                                mem_req.cnt_wdata = count_t'(1);
                                granted_slot_next = slot_port(ins_slot);
                                new_count_next    = count_port(count_t'(1));
                            end
                            else
                            begin
                                granted_slot_next = '0;
                                status_next       = ST_FULL;
                            end
                        end
                        OP_PEEK:
                        begin
                            new_count_next = count_port(cur_cnt);
                        end
                        OP_RETAIN:
                        begin
                            if (!slot_ok || (cur_cnt == '0))
                            begin
                                status_next = ST_NOT_ALLOC;
                            end
                            else if (cur_cnt == COUNT_MAX)
                            begin
                                status_next    = ST_SATURATED;
                                new_count_next = count_port(cur_cnt);
                            end
                            else
                            begin
                                mem_req.cnt_we    = 1'b1;
                                mem_req.cnt_waddr = slot_i;
                                mem_req.cnt_wdata = cnt_inc;
                                new_count_next    = count_port(cnt_inc);
                            end
                        end
                        OP_RELEASE:
                        begin
                            if (!slot_ok)
                            begin
                                status_next = ST_NOT_ALLOC;
                            end
                            else if (cur_cnt == '0)
                            begin
                                status_next = ST_REL_ZERO;
                            end
                            else
                            begin
                                mem_req.cnt_we    = 1'b1;
                                mem_req.cnt_waddr = slot_i;
                                mem_req.cnt_wdata = cnt_dec;
                                new_count_next    = count_port(cnt_dec);
                                if ((cnt_dec == '0) && (free_depth_reg != depth_t'(SLOTS)))
                                begin
                                    mem_req.stk_we    = 1'b1;
                                    mem_req.stk_waddr = free_depth_reg[SLOT_W-1:0];
                                    mem_req.stk_wdata = slot_i;
                                    free_depth_next   = free_depth_reg + depth_t'(1);
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            free_depth_reg   <= '0;
            high_water_reg   <= '0;
            out_valid_reg    <= 1'b0;
            granted_slot_reg <= '0;
            new_count_reg    <= '0;
            status_reg       <= ST_OK;
        end
        else
        begin
            state_reg        <= state_next;
            free_depth_reg   <= free_depth_next;
            high_water_reg   <= high_water_next;
            out_valid_reg    <= out_valid_next;
            granted_slot_reg <= granted_slot_next;
            new_count_reg    <= new_count_next;
            status_reg       <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= opcode_t'(opcode);
            slot_reg  <= slot;
            value_reg <= value_fit(value);
        end
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            value_mem[val_waddr] <= value_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted_slot = granted_slot_reg;
    assign new_count    = new_count_reg;
    assign status       = status_reg;

    `RCSA_ASSERT_NEXT(a_accept_to_exec, accept, state_reg == S_EXEC)
    `RCSA_ASSERT_NOW(a_write_in_exec, mem_req.cnt_we || mem_req.stk_we, exec_fire)
    `RCSA_ASSERT_NOW(a_free_le_hw, 1'b1, free_depth_reg <= high_water_reg)
    `RCSA_ASSERT_NOW(a_hw_bound, 1'b1, high_water_reg <= depth_t'(SLOTS))

endmodule

// ===== dv/allocator_checker.sv =====
// Checker for the slot allocator: mirrors its counts and free stack and compares results
`timescale 1ns / 1ps

module allocator_checker
    import rcsa_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  logic [OPCODE_W-1:0]    opcode,
    input  logic [SLOT_IN_W-1:0]   slot,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  logic [SLOT_IN_W-1:0]   granted_slot,
    input  logic [COUNT_OUT_W-1:0] new_count,
    input  logic [STATUS_W-1:0]    status,
    output int                     failures,
    output int                     pending
);

    typedef struct packed {
        logic [SLOT_IN_W-1:0]   gslot;
        logic [COUNT_OUT_W-1:0] cnt;
        status_t                st;
    } grant_t;

    count_t counts [SLOTS];
    slot_t  freed  [SLOTS];
    depth_t free_top;
    depth_t hwm;
    grant_t owed_grants [$];

    function automatic grant_t allocate_step(input opcode_t op,
                                             input logic [SLOT_IN_W-1:0] s);
        grant_t r;
        slot_t  idx;
        depth_t top_m1;
        r = '{gslot: s, cnt: '0, st: ST_OK};
        if (op == OP_INSERT) begin
            if (free_top != '0) begin
                top_m1   = free_top - depth_t'(1);
                idx      = freed[top_m1[SLOT_W-1:0]];
                free_top = top_m1;
            end
            else if (hwm < depth_t'(SLOTS)) begin
                idx = hwm[SLOT_W-1:0];
                hwm = hwm + depth_t'(1);
            end
            else begin
                r.gslot = '0;
                r.st    = ST_FULL;
                return r;
            end
            counts[idx] = count_t'(1);
            r.gslot     = idx;
            r.cnt       = count_t'(1);
        end
        else if (op == OP_PEEK) begin
            r.cnt = counts[s];
        end
        else if (s >= hwm) begin
            r.st = ST_NOT_ALLOC;
        end
        else if (op == OP_RETAIN) begin
            if (counts[s] == '0) begin
                r.st = ST_NOT_ALLOC;
            end
            else if (counts[s] == COUNT_MAX) begin
                r.cnt = counts[s];
                r.st  = ST_SATURATED;
            end
            else begin
                counts[s] = counts[s] + count_t'(1);
                r.cnt     = counts[s];
            end
        end
        else begin
            if (counts[s] == '0) begin
                r.st = ST_REL_ZERO;
            end
            else begin
                counts[s] = counts[s] - count_t'(1);
                r.cnt     = counts[s];
                if (counts[s] == '0 && free_top < depth_t'(SLOTS)) begin
                    freed[free_top[SLOT_W-1:0]] = s;
                    free_top                    = free_top + depth_t'(1);
                end
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grant_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                counts[i] = '0;
            end
            free_top = '0;
            hwm      = '0;
            owed_grants.delete();
            failures <= 0;
            pending  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (owed_grants.size() == 0)
                begin
                    $error("result transaction with nothing outstanding: slot %0d count %0d status %0d",
                           granted_slot, new_count, status);
                    failures <= failures + 1;
                end
                else
                begin
                    want = owed_grants.pop_front();
                    if (granted_slot !== want.gslot || new_count !== want.cnt
                        || status !== want.st)
                    begin
                        failures <= failures + 1;
                    end
                    if (granted_slot !== want.gslot)
                    begin
                        $error("granted_slot: expected %0d, got %0d", want.gslot, granted_slot);
                    end
                    if (new_count !== want.cnt)
                    begin
                        $error("new_count: expected %0d, got %0d", want.cnt, new_count);
                    end
                    if (status !== want.st)
                    begin
                        $error("status: expected %0d, got %0d", want.st, status);
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                owed_grants = {owed_grants, allocate_step(opcode_t'(opcode), slot)};
            end
            pending <= owed_grants.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
// Testbench top for the slot allocator: reset, stimulus, stalls and verdict
`timescale 1ns / 1ps

module tb;
    import rcsa_pkg::*;

    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 460;
    localparam int CALM_ITEMS = 120;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    logic [OPCODE_W-1:0]    opcode;
    logic [SLOT_IN_W-1:0]   slot;
    logic [VALUE_IN_W-1:0]  value;
    logic                   out_valid;
    logic                   out_ready;
    logic [SLOT_IN_W-1:0]   granted_slot;
    logic [COUNT_OUT_W-1:0] new_count;
    logic [STATUS_W-1:0]    status;

    int failures;
    int pending;
    int quiet;
    bit idling;

    always #6 clk = ~clk;

    refcounted_slot_allocator_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_slot (granted_slot),
        .new_count    (new_count),
        .status       (status)
    );

    allocator_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .slot         (slot),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .granted_slot (granted_slot),
        .new_count    (new_count),
        .status       (status),
        .failures     (failures),
        .pending      (pending)
    );

    task automatic issue(input opcode_t op, input logic [SLOT_IN_W-1:0] s,
                         input logic [VALUE_IN_W-1:0] v);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        slot     <= s;
        value    <= v;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // receiver stalls
    initial
    begin
        out_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (idling && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= QUIET_LIMIT)
        begin
            $display("[refcounted_slot_allocator_top] ERROR");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        int pick;
        opcode_t op;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        opcode   <= OP_INSERT;
        slot     <= '0;
        value    <= '0;
        idling   = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing handed out yet
        issue(OP_RELEASE, 8'd0,   32'hFFFF_FFFF);
        issue(OP_RETAIN,  8'd255, 32'h0);
        issue(OP_PEEK,    8'd255, 32'h0);
        issue(OP_INSERT,  8'd255, 32'h0);
        issue(OP_INSERT,  8'd0,   32'hFFFF_FFFF);
        issue(OP_INSERT,  8'd170, 32'hA5A5_A5A5);
        issue(OP_RETAIN,  8'd1,   32'h5A5A_5A5A);
        issue(OP_RELEASE, 8'd1,   32'h0);
        issue(OP_RELEASE, 8'd1,   32'h0);
        // freed slot: retain refused, release at zero
        issue(OP_RETAIN,  8'd1,   32'h0);
        issue(OP_RELEASE, 8'd1,   32'h0);
        issue(OP_PEEK,    8'd1,   32'h0);
        issue(OP_INSERT,  8'd85,  32'h1234_5678);
        issue(OP_RELEASE, 8'd0,   32'h0);
        issue(OP_RELEASE, 8'd2,   32'h0);
        issue(OP_INSERT,  8'd0,   32'h8000_0000);
        issue(OP_INSERT,  8'd0,   32'h0000_0001);
        issue(OP_INSERT,  8'd0,   32'h7FFF_FFFF);
        issue(OP_PEEK,    8'd0,   32'hFFFF_FFFF);
        issue(OP_RETAIN,  8'd200, 32'h0);
        issue(OP_RELEASE, 8'd128, 32'h0);

        // fill the table, then two inserts against a full table
        repeat (254) issue(OP_INSERT, 8'($urandom_range(0, 255)), $urandom());

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - CALM_ITEMS)
            begin
                idling = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                op = OP_INSERT;
            else if (pick < 62)
                op = OP_RETAIN;
            else if (pick < 95)
                op = OP_RELEASE;
            else
                op = OP_PEEK;
            issue(op, 8'($urandom_range(0, 255)), $urandom());
        end
        in_valid <= 1'b0;

        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
        if (failures == 0)
        begin
            $display("[refcounted_slot_allocator_top] OK");
        end
        else
        begin
            $display("[refcounted_slot_allocator_top] ERROR");
        end
        $finish;
    end

endmodule
